FILE: rtl/core/cdag_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths, codes and reset values for the clip-driven auto gain block.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
package cdag_pkg;

  localparam int CNT_W      = 11;  // read length and clip tally, up to 2047
  localparam int RUN_W      = 23;  // overload and clean run counters
  localparam int GAIN_W     = 17;  // Q16 gain, ratios, floor and ceiling
  localparam int PCT_W      = 7;
  localparam int STEP_W     = 2;
  localparam int THR_W      = 31;
  localparam int LIM_W      = 22;
  localparam int SAMPLE_W   = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 31;
  localparam int Q_FRAC     = 16;

  localparam int MAX_READ_DEF    = 1024;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [RUN_W-1:0]  RUN_MAX   = {RUN_W{1'b1}};
  localparam logic [GAIN_W-1:0] GAIN_MAX  = {GAIN_W{1'b1}};
  localparam logic [PCT_W-1:0]  PCT_MAX   = {PCT_W{1'b1}};
  localparam logic [PCT_W-1:0]  PCT_SCALE = 7'd100;

  // Step codes carried in the result.
  localparam logic [STEP_W-1:0] STEP_NONE = 2'd0;
  localparam logic [STEP_W-1:0] STEP_DOWN = 2'd1;
  localparam logic [STEP_W-1:0] STEP_UP   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_CLIP_THRESHOLD   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CLIP_PERCENT     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEPDOWN_SAMPLES = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEPUP_SAMPLES   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_DOWN_RATIO       = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_UP_RATIO         = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_FLOOR       = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_CEILING     = 3'd7;

  // Register reset values.
  localparam logic [THR_W-1:0]  RST_CLIP_THRESHOLD   = 31'd1932735283;
  localparam logic [PCT_W-1:0]  RST_CLIP_PERCENT     = 7'd1;
  localparam logic [LIM_W-1:0]  RST_STEPDOWN_SAMPLES = 22'd144000;
  localparam logic [LIM_W-1:0]  RST_STEPUP_SAMPLES   = 22'd1440000;
  localparam logic [GAIN_W-1:0] RST_DOWN_RATIO       = 17'd46399;
  localparam logic [GAIN_W-1:0] RST_UP_RATIO         = 17'd73531;
  localparam logic [GAIN_W-1:0] RST_GAIN_FLOOR       = 17'd3277;
  localparam logic [GAIN_W-1:0] RST_GAIN_CEILING     = 17'd65536;
  localparam logic [GAIN_W-1:0] RST_GAIN             = 17'd65536;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_of_read;
  } in_item_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [PCT_W-1:0]  gain_percent;
    logic [STEP_W-1:0] step_taken;
    logic              read_overloaded;
  } out_item_t;

  typedef struct packed {
    logic [THR_W-1:0]  clip_threshold;
    logic [PCT_W-1:0]  clip_percent;
    logic [LIM_W-1:0]  stepdown_samples;
    logic [LIM_W-1:0]  stepup_samples;
    logic [GAIN_W-1:0] down_ratio;
    logic [GAIN_W-1:0] up_ratio;
    logic [GAIN_W-1:0] gain_floor;
    logic [GAIN_W-1:0] gain_ceiling;
  } cfg_t;

  // Summary of one finished read, handed from the front end to the back end.
  typedef struct packed {
    logic [CNT_W-1:0] tally;
    logic [CNT_W-1:0] length;
  } read_rec_t;

endpackage

FILE: rtl/core/clip_driven_auto_gain.sv
`timescale 1ns / 1ps
// Throughput: one sample transaction per cycle, including reads of one sample, unless the queue is full.
// A read's result passes the summary queue, the stage 1 and stage 2 registers and the output register.
// The per-read gain update (one Q16 multiply and clamp) is combinational from the gain register back into it.
// Reset (rst_n low, synchronous): registers return to defaults, gain to unity, counts clear.
// Samples are held off only while the read-summary queue is full behind a stalled output.
module clip_driven_auto_gain #(
  parameter int MAX_READ    = cdag_pkg::MAX_READ_DEF,
  parameter int QUEUE_DEPTH = cdag_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  cdag_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output cdag_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [cdag_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [cdag_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // The front end counts samples and clipped samples within each read. When a read
  // ends (marked by the last-of-read flag, or by reaching MAX_READ samples) it
  // pushes a summary of the read into a short queue. The back end pops one summary
  // per cycle unless its result is stalled, judges the read, updates the run counters
  // and the gain, and places the result in an output register. A stalled result
  // stalls only the back end; the queue absorbs finished reads until it fills.

  cdag_pkg::cfg_t      cfg_r;
  cdag_pkg::read_rec_t push_rec;
  cdag_pkg::read_rec_t pop_rec;
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;

  // Configuration registers. Writes are expected only while the block is idle,
  // so no read in flight ever sees a change.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clip_threshold   <= cdag_pkg::RST_CLIP_THRESHOLD;
      cfg_r.clip_percent     <= cdag_pkg::RST_CLIP_PERCENT;
      cfg_r.stepdown_samples <= cdag_pkg::RST_STEPDOWN_SAMPLES;
      cfg_r.stepup_samples   <= cdag_pkg::RST_STEPUP_SAMPLES;
      cfg_r.down_ratio       <= cdag_pkg::RST_DOWN_RATIO;
      cfg_r.up_ratio         <= cdag_pkg::RST_UP_RATIO;
      cfg_r.gain_floor       <= cdag_pkg::RST_GAIN_FLOOR;
      cfg_r.gain_ceiling     <= cdag_pkg::RST_GAIN_CEILING;
    end else if (cfg_we) begin
      case (cfg_addr)
        cdag_pkg::CFG_CLIP_THRESHOLD: begin
          cfg_r.clip_threshold <= cfg_wdata[cdag_pkg::THR_W-1:0];
        end
        cdag_pkg::CFG_CLIP_PERCENT: begin
          cfg_r.clip_percent <= cfg_wdata[cdag_pkg::PCT_W-1:0];
        end
        cdag_pkg::CFG_STEPDOWN_SAMPLES: begin
          cfg_r.stepdown_samples <= cfg_wdata[cdag_pkg::LIM_W-1:0];
        end
        cdag_pkg::CFG_STEPUP_SAMPLES: begin
          cfg_r.stepup_samples <= cfg_wdata[cdag_pkg::LIM_W-1:0];
        end
        cdag_pkg::CFG_DOWN_RATIO: begin
          cfg_r.down_ratio <= cfg_wdata[cdag_pkg::GAIN_W-1:0];
        end
        cdag_pkg::CFG_UP_RATIO: begin
          cfg_r.up_ratio <= cfg_wdata[cdag_pkg::GAIN_W-1:0];
        end
        cdag_pkg::CFG_GAIN_FLOOR: begin
          cfg_r.gain_floor <= cfg_wdata[cdag_pkg::GAIN_W-1:0];
        end
        cdag_pkg::CFG_GAIN_CEILING: begin
          cfg_r.gain_ceiling <= cfg_wdata[cdag_pkg::GAIN_W-1:0];
        end
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  cdag_front #(
    .MAX_READ (MAX_READ)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .clip_threshold (cfg_r.clip_threshold),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_rec          (push_rec)
  );

  cdag_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .rec_in  (push_rec),
    .pop     (q_pop),
    .rec_out (pop_rec),
    .full    (q_full),
    .empty   (q_empty)
  );

  cdag_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_rec     (pop_rec),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/core/cdag_front.sv
`timescale 1ns / 1ps
// Front end: accepts samples, flags clipped ones and counts each read.
// Depends on cdag_pkg.
module cdag_front #(
  parameter int MAX_READ = cdag_pkg::MAX_READ_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  cdag_pkg::in_item_t                  in_data,
  input  logic [cdag_pkg::THR_W-1:0]          clip_threshold,
  input  logic                                q_full,
  output logic                                q_push,
  output cdag_pkg::read_rec_t                 q_rec
);

  localparam int CW = cdag_pkg::CNT_W;
  localparam int SW = cdag_pkg::SAMPLE_W;

  logic [CW-1:0] tally_r, tally_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [SW-1:0] raw;
  logic [SW-1:0] mag;
  logic          clip;
  logic          accept;
  logic          read_end;
  logic [CW-1:0] tally_inc;
  logic [CW-1:0] len_inc;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // The magnitude of the most negative sample is 2^31, which still fits unsigned.
  assign raw  = in_data.sample;
  assign mag  = raw[SW-1] ? SW'(~raw + SW'(1)) : raw;
  assign clip = mag > {1'b0, clip_threshold};

  assign tally_inc = tally_r + CW'(clip);
  assign len_inc   = len_r + CW'(1);
  assign read_end  = in_data.last_of_read || (len_inc == CW'(MAX_READ));

  assign q_push       = accept && read_end;
  assign q_rec.tally  = tally_inc;
  assign q_rec.length = len_inc;

  always_comb begin
    tally_nxt = tally_r;
    len_nxt   = len_r;
    if (accept) begin
      if (read_end) begin
        tally_nxt = '0;
        len_nxt   = '0;
      end else begin
        tally_nxt = tally_inc;
        len_nxt   = len_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r <= '0;
      len_r   <= '0;
    end else begin
      tally_r <= tally_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

FILE: rtl/core/cdag_queue.sv
`timescale 1ns / 1ps
// Short queue of finished read summaries between the front and back ends.
// Depends on cdag_pkg.
module cdag_queue #(
  parameter int DEPTH = cdag_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cdag_pkg::read_rec_t rec_in,
  input  logic                pop,
  output cdag_pkg::read_rec_t rec_out,
  output logic                full,
  output logic                empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cdag_pkg::read_rec_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = count_r == CNT_W'(DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rec_out = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= rec_in;
    end
  end

  // The front end holds off samples while the queue is full, so no summary is dropped.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("read summary pushed into a full queue");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue occupancy beyond its depth");

endmodule

FILE: rtl/core/cdag_back.sv
`timescale 1ns / 1ps
// Back end: judges each read, updates the run counters and the gain, drives results.
// Depends on cdag_pkg.
module cdag_back (
  input  logic                clk,
  input  logic                rst_n,
  input  cdag_pkg::cfg_t      cfg,
  input  logic                q_empty,
  input  cdag_pkg::read_rec_t q_rec,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output cdag_pkg::out_item_t out_data
);

  localparam int CW     = cdag_pkg::CNT_W;
  localparam int RW     = cdag_pkg::RUN_W;
  localparam int GW     = cdag_pkg::GAIN_W;
  localparam int PW     = cdag_pkg::PCT_W;
  localparam int QF     = cdag_pkg::Q_FRAC;
  localparam int PROD_W = CW + PW;
  localparam int MUL_W  = 2 * GW;
  localparam int PCTP_W = GW + PW;

  logic                        pipe_en;

  // Stage 1: verdict on the read.
  logic                        s1_valid_r;
  logic                        s1_over_r;
  logic [CW-1:0]               s1_len_r;
  logic [PROD_W-1:0]           tally_scaled;
  logic [PROD_W-1:0]           len_scaled;
  logic                        over_now;

  // Stage 2: run counters and gain.
  logic                        s2_valid_r;
  logic                        s2_over_r;
  logic [cdag_pkg::STEP_W-1:0] s2_step_r, s2_step_nxt;
  logic [RW-1:0]               ovl_run_r, ovl_run_nxt;
  logic [RW-1:0]               cln_run_r, cln_run_nxt;
  logic [GW-1:0]               gain_r, gain_nxt;
  logic [RW:0]                 ovl_sum, cln_sum;
  logic [RW-1:0]               ovl_sat, cln_sat;
  logic                        down_hit, up_hit;
  logic [MUL_W-1:0]            down_prod, up_prod;
  logic [GW-1:0]               down_sat, up_sat;
  logic [GW-1:0]               down_gain, up_gain;

  // Stage 3: output register.
  logic                        out_valid_r;
  cdag_pkg::out_item_t         out_data_r;
  logic [PCTP_W-1:0]           pct_prod;
  logic [PCTP_W-QF-1:0]        pct_raw;
  logic [PW-1:0]               pct;

  // The whole back end moves together whenever the output register can take a value.
  assign pipe_en = !out_valid_r || !out_stall;
  assign q_pop   = pipe_en && !q_empty;

  // tally > floor(len * pct / 100) holds exactly when 100 * tally > len * pct.
  assign tally_scaled = PROD_W'(q_rec.tally) * PROD_W'(cdag_pkg::PCT_SCALE);
  assign len_scaled   = PROD_W'(q_rec.length) * PROD_W'(cfg.clip_percent);
  assign over_now     = tally_scaled > len_scaled;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_r <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_over_r <= over_now;
      s1_len_r  <= q_rec.length;
    end
  end

  assign ovl_sum  = {1'b0, ovl_run_r} + (RW + 1)'(s1_len_r);
  assign cln_sum  = {1'b0, cln_run_r} + (RW + 1)'(s1_len_r);
  assign ovl_sat  = ovl_sum[RW] ? cdag_pkg::RUN_MAX : ovl_sum[RW-1:0];
  assign cln_sat  = cln_sum[RW] ? cdag_pkg::RUN_MAX : cln_sum[RW-1:0];
  assign down_hit = ovl_sat >= RW'(cfg.stepdown_samples);
  assign up_hit   = cln_sat >= RW'(cfg.stepup_samples);

  // Both candidate products come straight from the gain register.
  assign down_prod = MUL_W'(gain_r) * MUL_W'(cfg.down_ratio);
  assign up_prod   = MUL_W'(gain_r) * MUL_W'(cfg.up_ratio);
  assign down_sat  = down_prod[QF+GW] ? cdag_pkg::GAIN_MAX : down_prod[QF+GW-1:QF];
  assign up_sat    = up_prod[QF+GW] ? cdag_pkg::GAIN_MAX : up_prod[QF+GW-1:QF];
  assign down_gain = (down_sat < cfg.gain_floor) ? cfg.gain_floor : down_sat;
  assign up_gain   = (up_sat > cfg.gain_ceiling) ? cfg.gain_ceiling : up_sat;

  always_comb begin
    ovl_run_nxt = ovl_run_r;
    cln_run_nxt = cln_run_r;
    gain_nxt    = gain_r;
    s2_step_nxt = cdag_pkg::STEP_NONE;
    if (s1_over_r) begin
      cln_run_nxt = '0;
      if (down_hit) begin
        ovl_run_nxt = '0;
        gain_nxt    = down_gain;
        s2_step_nxt = cdag_pkg::STEP_DOWN;
      end else begin
        ovl_run_nxt = ovl_sat;
      end
    end else begin
      ovl_run_nxt = '0;
      if (up_hit) begin
        cln_run_nxt = '0;
        gain_nxt    = up_gain;
        s2_step_nxt = cdag_pkg::STEP_UP;
      end else begin
        cln_run_nxt = cln_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      ovl_run_r  <= '0;
      cln_run_r  <= '0;
      gain_r     <= cdag_pkg::RST_GAIN;
    end else if (pipe_en) begin
      s2_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        ovl_run_r <= ovl_run_nxt;
        cln_run_r <= cln_run_nxt;
        gain_r    <= gain_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en && s1_valid_r) begin
      s2_step_r <= s2_step_nxt;
      s2_over_r <= s1_over_r;
    end
  end

  // gain_r already holds the gain that stage 2 produced for the read it carries.
  assign pct_prod = PCTP_W'(gain_r) * PCTP_W'(cdag_pkg::PCT_SCALE);
  assign pct_raw  = pct_prod[PCTP_W-1:QF];
  assign pct      = (pct_raw > (PCTP_W - QF)'(cdag_pkg::PCT_MAX)) ? cdag_pkg::PCT_MAX
                                                                   : pct_raw[PW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en && s2_valid_r) begin
      out_data_r.gain            <= gain_r;
      out_data_r.gain_percent    <= pct;
      out_data_r.step_taken      <= s2_step_r;
      out_data_r.read_overloaded <= s2_over_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A read clears the opposite run, so at most one run is ever counting.
  a_runs_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !((ovl_run_r != '0) && (cln_run_r != '0)))
    else $error("overload and clean runs both nonzero");

  // A stalled result freezes the whole back end.
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> $stable(s1_valid_r) && $stable(gain_r))
    else $error("back end advanced while its result was stalled");

  // A step up only follows a clean read, a step down only an overloaded one.
  a_step_matches_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      !((out_data_r.step_taken == cdag_pkg::STEP_UP) && out_data_r.read_overloaded) &&
      !((out_data_r.step_taken == cdag_pkg::STEP_DOWN) && !out_data_r.read_overloaded))
    else $error("gain step disagrees with the read verdict");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for clip_driven_auto_gain: directed table, then random reads.
// Depends on cdag_pkg for the transaction types, step codes and register indexes.
module testbench;
  import cdag_pkg::*;

  // Reads end on their own at this many samples, as in the block's default build.
  localparam int READ_CAP = MAX_READ_DEF;
  // Random samples per register setting.
  localparam int SEG_ITEMS = 90;
  // Cycles with no transaction on either channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 4000;
  // Cycles allowed after the last expected result for anything still in flight.
  localparam int SETTLE_CYCLES = 8;

  // One row of the directed table: either a register write or one sample transaction.
  // A sample row may carry a typed-in expectation that replaces the predicted one.
  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;
    in_item_t              item;
    logic                  typed;
    out_item_t             want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Results the predictor has produced and the block has not yet delivered, oldest first.
  out_item_t gain_expect_q[$];
  out_item_t oldest_gain;
  int        fail_count = 0;
  int        idle_cycles = 0;
  // Percent chance per cycle that the sender idles or the receiver stalls.
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  // Shadow copy of the block's registers, kept in step with every write.
  cfg_t gain_cfg = '{
    clip_threshold:   RST_CLIP_THRESHOLD,
    clip_percent:     RST_CLIP_PERCENT,
    stepdown_samples: RST_STEPDOWN_SAMPLES,
    stepup_samples:   RST_STEPUP_SAMPLES,
    down_ratio:       RST_DOWN_RATIO,
    up_ratio:         RST_UP_RATIO,
    gain_floor:       RST_GAIN_FLOOR,
    gain_ceiling:     RST_GAIN_CEILING
  };

  // Predictor state: the gain, the two run counters and the read in progress.
  logic [GAIN_W-1:0] model_gain = RST_GAIN;
  logic [RUN_W-1:0]  model_overload_run = '0;
  logic [RUN_W-1:0]  model_clean_run = '0;
  logic [CNT_W-1:0]  model_clip_tally = '0;
  logic [CNT_W-1:0]  model_read_len = '0;

  plan_row_t plan[$];

  clip_driven_auto_gain i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Q16 gain times a Q16 ratio, truncated, saturated to the gain width.
  function automatic logic [GAIN_W-1:0] scaled_gain(input logic [GAIN_W-1:0] g,
                                                    input logic [GAIN_W-1:0] ratio);
    logic [2*GAIN_W-1:0] prod;
    logic [2*GAIN_W-1:0] g_w;
    logic [2*GAIN_W-1:0] r_w;
    g_w = (2*GAIN_W)'(g);
    r_w = (2*GAIN_W)'(ratio);
    prod = (g_w * r_w) >> Q_FRAC;
    if (prod > (2*GAIN_W)'(GAIN_MAX)) return GAIN_MAX;
    return prod[GAIN_W-1:0];
  endfunction

  // Advances the predictor by one accepted sample. Returns 1 when the sample closes a
  // read, either by its last_of_read flag or by the read reaching READ_CAP samples,
  // and then fills in the verdict the block must report for that read.
  function automatic bit next_gain_verdict(input in_item_t it, output out_item_t res);
    logic signed [SAMPLE_W:0] smp;
    logic signed [SAMPLE_W:0] thr;
    logic [31:0]              len_w;
    logic [31:0]              tally_w;
    logic [31:0]              pct_w;
    logic [31:0]              bound;
    logic [RUN_W:0]           run_sum;
    logic [GAIN_W-1:0]        g;
    logic [31:0]              gain_w;
    logic [31:0]              shown_pct;
    logic                     over;
    logic [STEP_W-1:0]        step;
    res = '0;
    smp = {it.sample[SAMPLE_W-1], it.sample};
    thr = {2'b00, gain_cfg.clip_threshold};
    if (smp > thr || smp < -thr) model_clip_tally = model_clip_tally + 1'b1;
    model_read_len = model_read_len + 1'b1;
    if (!it.last_of_read && model_read_len < READ_CAP) return 1'b0;

    len_w = 32'(model_read_len);
    tally_w = 32'(model_clip_tally);
    pct_w = 32'(gain_cfg.clip_percent);
    bound = (len_w * pct_w) / 32'd100;
    over = tally_w > bound;
    step = STEP_NONE;
    if (over) begin
      model_clean_run = '0;
      run_sum = (RUN_W+1)'(model_overload_run) + (RUN_W+1)'(model_read_len);
      model_overload_run = (run_sum > RUN_MAX) ? RUN_MAX : run_sum[RUN_W-1:0];
      if (model_overload_run >= gain_cfg.stepdown_samples) begin
        g = scaled_gain(model_gain, gain_cfg.down_ratio);
        model_overload_run = '0;
        if (g < gain_cfg.gain_floor) g = gain_cfg.gain_floor;
        model_gain = g;
        step = STEP_DOWN;
      end
    end else begin
      model_overload_run = '0;
      run_sum = (RUN_W+1)'(model_clean_run) + (RUN_W+1)'(model_read_len);
      model_clean_run = (run_sum > RUN_MAX) ? RUN_MAX : run_sum[RUN_W-1:0];
      if (model_clean_run >= gain_cfg.stepup_samples) begin
        g = scaled_gain(model_gain, gain_cfg.up_ratio);
        model_clean_run = '0;
        if (g > gain_cfg.gain_ceiling) g = gain_cfg.gain_ceiling;
        model_gain = g;
        step = STEP_UP;
      end
    end
    model_clip_tally = '0;
    model_read_len = '0;

    gain_w = 32'(model_gain);
    shown_pct = (gain_w * 32'd100) >> Q_FRAC;
    if (shown_pct > 32'(PCT_MAX)) shown_pct = 32'(PCT_MAX);
    res.gain = model_gain;
    res.gain_percent = shown_pct[PCT_W-1:0];
    res.step_taken = step;
    res.read_overloaded = over;
    return 1'b1;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_ADDR_W-1:0] a,
                                        input int unsigned d);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.addr = a;
    r.data = CFG_DATA_W'(d);
    return r;
  endfunction

  function automatic plan_row_t sample_row(input logic [SAMPLE_W-1:0] s, input logic l,
                                           input logic typed, input out_item_t w);
    plan_row_t r;
    r = '0;
    r.item.sample = s;
    r.item.last_of_read = l;
    r.typed = typed;
    r.want = w;
    return r;
  endfunction

  // Mostly a value from the given range, with each extreme one time in eight.
  function automatic logic [CFG_DATA_W-1:0] pick_reg(input int unsigned lo, input int unsigned hi,
                                                     input int unsigned rlo, input int unsigned rhi);
    case ($urandom_range(7))
      0: return CFG_DATA_W'(lo);
      1: return CFG_DATA_W'(hi);
      default: return CFG_DATA_W'($urandom_range(rhi, rlo));
    endcase
  endfunction

  // A raw sample placed relative to the current threshold: just beyond it with the given
  // percent chance, otherwise on or just inside it. One in eight is fully random.
  function automatic logic [SAMPLE_W-1:0] draw_sample(input int clip_pct);
    logic [SAMPLE_W:0]   mag;
    logic [SAMPLE_W-1:0] thr_w;
    logic                neg;
    thr_w = SAMPLE_W'(gain_cfg.clip_threshold);
    neg = 1'($urandom_range(1));
    if ($urandom_range(7) == 0) return $urandom;
    if ($urandom_range(99) < clip_pct) begin
      mag = (SAMPLE_W+1)'(thr_w) + (SAMPLE_W+1)'($urandom_range(64, 1));
      if (neg) begin
        if (mag > 33'h080000000) mag = 33'h080000000;
        return -mag[SAMPLE_W-1:0];
      end
      if (mag > 33'h07FFFFFFF) mag = 33'h07FFFFFFF;
      return mag[SAMPLE_W-1:0];
    end
    if (thr_w > 64) mag = (SAMPLE_W+1)'(thr_w - $urandom_range(64, 0));
    else mag = (SAMPLE_W+1)'($urandom_range(thr_w, 0));
    return neg ? -mag[SAMPLE_W-1:0] : mag[SAMPLE_W-1:0];
  endfunction

  // Drives one register write and holds it for one edge. The caller lowers cfg_we after a
  // batch, so back-to-back writes keep the enable high without a glitch.
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= d;
    @(posedge clk);
    case (a)
      CFG_CLIP_THRESHOLD:   gain_cfg.clip_threshold = d[THR_W-1:0];
      CFG_CLIP_PERCENT:     gain_cfg.clip_percent = d[PCT_W-1:0];
      CFG_STEPDOWN_SAMPLES: gain_cfg.stepdown_samples = d[LIM_W-1:0];
      CFG_STEPUP_SAMPLES:   gain_cfg.stepup_samples = d[LIM_W-1:0];
      CFG_DOWN_RATIO:       gain_cfg.down_ratio = d[GAIN_W-1:0];
      CFG_UP_RATIO:         gain_cfg.up_ratio = d[GAIN_W-1:0];
      CFG_GAIN_FLOOR:       gain_cfg.gain_floor = d[GAIN_W-1:0];
      CFG_GAIN_CEILING:     gain_cfg.gain_ceiling = d[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // Holds the sender back until every predicted result has been delivered, then lets the
  // pipeline settle so that a register write lands on an idle block.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (gain_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offers one sample transaction, idling first at the current rate, and waits until it
  // is accepted. in_valid stays high on return so that back-to-back samples need no
  // second assignment in the same time step.
  task automatic send_sample(input in_item_t it, input logic typed, input out_item_t want);
    out_item_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    // Sampled right after the edge, in_stall still holds the value it had at the edge.
    do @(posedge clk); while (in_stall);
    if (next_gain_verdict(it, res)) gain_expect_q.push_back(typed ? want : res);
  endtask

  task automatic load_random_config();
    drain_results();
    cfg_write(CFG_CLIP_THRESHOLD, pick_reg(0, 32'h7FFFFFFF, 0, 32'h7FFFFFFF));
    cfg_write(CFG_CLIP_PERCENT, pick_reg(100, 127, 0, 20));
    cfg_write(CFG_STEPDOWN_SAMPLES, pick_reg(0, 4194303, 1, 48));
    cfg_write(CFG_STEPUP_SAMPLES, pick_reg(0, 4194303, 1, 48));
    cfg_write(CFG_DOWN_RATIO, pick_reg(0, 65536, 0, 65536));
    cfg_write(CFG_UP_RATIO, pick_reg(65536, 131071, 65536, 131071));
    cfg_write(CFG_GAIN_FLOOR, pick_reg(0, 65536, 0, 8000));
    cfg_write(CFG_GAIN_CEILING, pick_reg(0, 65536, 8000, 65536));
    cfg_we <= 1'b0;
  endtask

  // The receiver stalls at random at the current rate, redrawn every cycle.
  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Result checker: every accepted result is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (gain_expect_q.size() == 0) begin
        fail_count++;
        if (fail_count < 40)
          $display("%0t: unexpected result gain=%0d pct=%0d step=%0d over=%0d", $time,
                   out_data.gain, out_data.gain_percent, out_data.step_taken,
                   out_data.read_overloaded);
      end else begin
        oldest_gain = gain_expect_q.pop_front();
        if (out_data.gain !== oldest_gain.gain ||
            out_data.gain_percent !== oldest_gain.gain_percent ||
            out_data.step_taken !== oldest_gain.step_taken ||
            out_data.read_overloaded !== oldest_gain.read_overloaded) begin
          fail_count++;
          if (fail_count < 40)
            $display("%0t: mismatch expected gain=%0d pct=%0d step=%0d over=%0d",
                     $time, oldest_gain.gain, oldest_gain.gain_percent,
                     oldest_gain.step_taken, oldest_gain.read_overloaded);
          if (fail_count < 40)
            $display("%0t:   actual gain=%0d pct=%0d step=%0d over=%0d", $time,
                     out_data.gain, out_data.gain_percent, out_data.step_taken,
                     out_data.read_overloaded);
        end
      end
    end
  end

  // Watchdog: a run in which no transaction moves on either channel for too long is hung.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    plan_row_t row;
    in_item_t  it;
    logic      cfg_open;
    int        seg;
    int        n;
    int        len;
    int        k;
    int        clip_pct;

    // Directed table. Under the reset settings the first rows probe the sample extremes
    // and both sides of the threshold, where the verdict can be read off directly.
    plan.push_back(sample_row(32'd0, 1'b1, 1'b1, {RST_GAIN, 7'd100, STEP_NONE, 1'b0}));
    plan.push_back(sample_row(32'h7FFFFFFF, 1'b1, 1'b1, {RST_GAIN, 7'd100, STEP_NONE, 1'b1}));
    plan.push_back(sample_row(32'h80000000, 1'b1, 1'b1, {RST_GAIN, 7'd100, STEP_NONE, 1'b1}));
    plan.push_back(sample_row(32'd1932735283, 1'b1, 1'b1, {RST_GAIN, 7'd100, STEP_NONE, 1'b0}));
    plan.push_back(sample_row(-32'sd1932735283, 1'b1, 1'b1,
                              {RST_GAIN, 7'd100, STEP_NONE, 1'b0}));
    // A three-sample read with one clip: the bound rounds down to zero.
    plan.push_back(sample_row(32'd100, 1'b0, 1'b0, '0));
    plan.push_back(sample_row(-32'sd100, 1'b0, 1'b0, '0));
    plan.push_back(sample_row(32'h7FFFFFFF, 1'b1, 1'b0, '0));
    // Zero step limits: every read steps the gain in its own direction.
    plan.push_back(cfg_row(CFG_STEPDOWN_SAMPLES, 0));
    plan.push_back(cfg_row(CFG_STEPUP_SAMPLES, 0));
    plan.push_back(cfg_row(CFG_DOWN_RATIO, 32768));
    plan.push_back(cfg_row(CFG_GAIN_FLOOR, 0));
    plan.push_back(sample_row(32'h7FFFFFFF, 1'b1, 1'b1, {17'd32768, 7'd50, STEP_DOWN, 1'b1}));
    plan.push_back(sample_row(32'd0, 1'b1, 1'b0, '0));
    // A zero ratio drives the gain to zero, and a step up cannot lift it again.
    plan.push_back(cfg_row(CFG_DOWN_RATIO, 0));
    plan.push_back(sample_row(32'h7FFFFFFF, 1'b1, 1'b1, {17'd0, 7'd0, STEP_DOWN, 1'b1}));
    plan.push_back(sample_row(32'd0, 1'b1, 1'b1, {17'd0, 7'd0, STEP_UP, 1'b0}));
    // A floor above the gain is applied on a step down only.
    plan.push_back(cfg_row(CFG_GAIN_FLOOR, 1000));
    plan.push_back(sample_row(32'h80000000, 1'b1, 1'b0, '0));
    // Floor, ceiling and ratio at full scale: the product saturates, and so does the
    // percent readout.
    plan.push_back(cfg_row(CFG_GAIN_FLOOR, 131071));
    plan.push_back(cfg_row(CFG_GAIN_CEILING, 131071));
    plan.push_back(cfg_row(CFG_UP_RATIO, 131071));
    plan.push_back(sample_row(32'h7FFFFFFF, 1'b1, 1'b1, {GAIN_MAX, PCT_MAX, STEP_DOWN, 1'b1}));
    plan.push_back(sample_row(32'd0, 1'b1, 1'b1, {GAIN_MAX, PCT_MAX, STEP_UP, 1'b0}));
    // Zero threshold with a percent above one hundred: the bound equals the length, so
    // a read where every sample clips is still clean.
    plan.push_back(cfg_row(CFG_GAIN_FLOOR, 0));
    plan.push_back(cfg_row(CFG_GAIN_CEILING, 65536));
    plan.push_back(cfg_row(CFG_CLIP_THRESHOLD, 0));
    plan.push_back(cfg_row(CFG_CLIP_PERCENT, 127));
    plan.push_back(cfg_row(CFG_STEPDOWN_SAMPLES, 4194303));
    plan.push_back(cfg_row(CFG_STEPUP_SAMPLES, 4194303));
    plan.push_back(sample_row(32'd5, 1'b0, 1'b0, '0));
    plan.push_back(sample_row(-32'sd5, 1'b0, 1'b0, '0));
    plan.push_back(sample_row(32'd1, 1'b1, 1'b1, {GAIN_MAX, PCT_MAX, STEP_NONE, 1'b0}));
    // Largest threshold: only the most negative sample lies beyond it.
    plan.push_back(cfg_row(CFG_CLIP_PERCENT, 0));
    plan.push_back(cfg_row(CFG_CLIP_THRESHOLD, 31'h7FFFFFFF));
    plan.push_back(sample_row(32'h80000000, 1'b1, 1'b1, {GAIN_MAX, PCT_MAX, STEP_NONE, 1'b1}));
    plan.push_back(sample_row(32'h7FFFFFFF, 1'b1, 1'b1, {GAIN_MAX, PCT_MAX, STEP_NONE, 1'b0}));
    plan.push_back(cfg_row(CFG_CLIP_PERCENT, 100));
    plan.push_back(sample_row(32'h80000000, 1'b0, 1'b0, '0));
    plan.push_back(sample_row(32'h80000000, 1'b1, 1'b1, {GAIN_MAX, PCT_MAX, STEP_NONE, 1'b0}));
    // A step up from above the ceiling is pulled back down to it.
    plan.push_back(cfg_row(CFG_STEPUP_SAMPLES, 1));
    plan.push_back(cfg_row(CFG_UP_RATIO, 65536));
    plan.push_back(sample_row(32'd0, 1'b1, 1'b1, {RST_GAIN, 7'd100, STEP_UP, 1'b0}));

    // Reset is held from time zero and released once.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 30;
    recv_stall_pct = 73;
    cfg_open = 1'b0;
    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_cfg) begin
        if (!cfg_open) drain_results();
        cfg_write(row.addr, row.data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_we <= 1'b0;
        cfg_open = 1'b0;
        send_sample(row.item, row.typed, row.want);
      end
    end

    // Random part: six register settings, two under each idling pattern. Reads are
    // mostly short so that verdicts and steps come often; one reaches the length cap.
    for (seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin
          send_idle_pct = 30;
          recv_stall_pct = 73;
        end
        1: begin
          send_idle_pct = 73;
          recv_stall_pct = 30;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      load_random_config();
      n = 0;
      while (n < SEG_ITEMS) begin
        // The first read of the first setting runs past the cap and is cut there; the
        // samples after the cut form a short read of their own.
        if (n == 0 && seg == 0) len = READ_CAP + $urandom_range(8, 1);
        else if ($urandom_range(9) == 0) len = $urandom_range(64, 13);
        else len = $urandom_range(12, 1);
        case ($urandom_range(3))
          0: clip_pct = 0;
          1: clip_pct = 100;
          default: clip_pct = $urandom_range(100);
        endcase
        // Now and then the sender waits for the block to deliver everything.
        if ($urandom_range(39) == 0) drain_results();
        for (k = 0; k < len; k++) begin
          it.sample = draw_sample(clip_pct);
          it.last_of_read = (k == len - 1);
          send_sample(it, 1'b0, '0);
        end
        n += len;
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/cdag_pkg.sv
rtl/core/cdag_front.sv
rtl/core/cdag_queue.sv
rtl/core/cdag_back.sv
rtl/core/clip_driven_auto_gain.sv
tb/testbench.sv
